// ===== rtl/lsbuu_pkg.sv =====
// Shared constants and the 6-bit to printable-character mapping for the
// LSB-first uuencode stream encoder. No dependencies.
`timescale 1ns / 1ps

package lsbuu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned CharW  = 7;
  localparam int unsigned GroupW = 3 * ByteW;
  localparam int unsigned CharsPerGroup = 4;
  localparam int unsigned OutDataW = 32;

  localparam logic [CharW-1:0] CharXor   = 7'h20;
  localparam logic [CharW-1:0] CharLift  = 7'h40;
  localparam logic [CharW-1:0] CharComma = 7'h2C;
  localparam logic [CharW-1:0] CharSpace = 7'h20;
  localparam logic [CharW-1:0] CharMin   = 7'h20;
  localparam logic [CharW-1:0] CharMax   = 7'h60;

  // Bytes already held in the current group.
  typedef logic [1:0] grp_pos_t;
  localparam grp_pos_t PosFirst  = 2'd0;
  localparam grp_pos_t PosSecond = 2'd1;
  localparam grp_pos_t PosThird  = 2'd2;

  typedef logic [CharW-1:0] char_t;

  function automatic char_t map_sextet(input logic [SextW-1:0] six);
    char_t v;
    v = {1'b0, six} ^ CharXor;
    if (v <= CharXor) begin
      v = v | CharLift;
    end
    if (v == CharComma) begin
      v = CharSpace;
    end
    return v;
  endfunction

endpackage

// ===== rtl/lsbuu_map.sv =====
// Maps one 24-bit group onto four printable characters, low sextet first.
// Depends on lsbuu_pkg.
`timescale 1ns / 1ps

module lsbuu_map (
  input  logic [lsbuu_pkg::GroupW-1:0] word,
  output lsbuu_pkg::char_t             chars [lsbuu_pkg::CharsPerGroup]
);

  always_comb begin
    for (int i = 0; i < lsbuu_pkg::CharsPerGroup; i++) begin
      chars[i] = lsbuu_pkg::map_sextet(word[i*lsbuu_pkg::SextW +: lsbuu_pkg::SextW]);
    end
  end

endmodule

// ===== rtl/lsb_first_uuencode_stream_encoder.sv =====
// LSB-first uuencode stream encoder: three bytes in, four printable characters out.
// A group's closing byte is registered into stage 1, then into the output register that drives m_tvalid.
// Throughput: one input byte per cycle, one character group per cycle out, while the output is not stalled.
// The output register stalls when full and not taken; stage 1 and the input stall only when stage 1 is also full.
// Reset (rst, synchronous, active high) drops any partial group and empties the pipe.
`timescale 1ns / 1ps

module lsb_first_uuencode_stream_encoder (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte: closes a partial group
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [6:0] char_first, [13:7] char_second,
                                 // [20:14] char_third, [27:21] char_fourth, [31:28] zero
);

  localparam int unsigned ByteW = lsbuu_pkg::ByteW;
  localparam int unsigned CharW = lsbuu_pkg::CharW;
  localparam int unsigned NChar = lsbuu_pkg::CharsPerGroup;
  localparam int unsigned PadW  = lsbuu_pkg::OutDataW - NChar * CharW;

  // Group assembly state
  lsbuu_pkg::grp_pos_t          pos;
  logic [2*ByteW-1:0]           held;
  lsbuu_pkg::grp_pos_t          pos_next;
  logic [2*ByteW-1:0]           held_next;
  logic [lsbuu_pkg::GroupW-1:0] word;
  logic                         emit;

  // Stage 1: assembled group waiting for the mapper
  logic                         s1_valid;
  logic [lsbuu_pkg::GroupW-1:0] s1_word;

  // Mapper outputs
  lsbuu_pkg::char_t             chars [NChar];
  logic [NChar*CharW-1:0]       chars_flat;

  logic out_ready;   // output register can load this cycle
  logic s1_ready;    // stage 1 can load this cycle
  logic in_xfer;

  assign out_ready = !m_tvalid || m_tready;
  assign s1_ready  = !s1_valid || out_ready;
  assign s_tready  = s1_ready;
  assign in_xfer   = s_tvalid && s_tready;

  // New byte lands above the bytes already held; missing bytes read as zero.
  always_comb begin
    word      = '0;
    held_next = held;
    pos_next  = pos;
    emit      = 1'b0;
    unique case (pos)
      lsbuu_pkg::PosSecond: begin
        word = {{ByteW{1'b0}}, s_tdata, held[ByteW-1:0]};
      end
      lsbuu_pkg::PosThird: begin
        word = {s_tdata, held};
      end
      default: begin
        word = {{(2*ByteW){1'b0}}, s_tdata};
      end
    endcase
    emit = (pos == lsbuu_pkg::PosThird) || s_tlast;
    if (emit) begin
      pos_next  = lsbuu_pkg::PosFirst;
      held_next = '0;
    end else begin
      pos_next  = (pos == lsbuu_pkg::PosSecond) ? lsbuu_pkg::PosThird
                                                : lsbuu_pkg::PosSecond;
      held_next = word[2*ByteW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= lsbuu_pkg::PosFirst;
      held <= '0;
    end else if (in_xfer) begin
      pos  <= pos_next;
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_xfer && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_xfer) begin
      s1_word <= word;
    end
  end

  lsbuu_map u_map (
    .word  (s1_word),
    .chars (chars)
  );

  always_comb begin
    for (int i = 0; i < NChar; i++) begin
      chars_flat[i*CharW +: CharW] = chars[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      m_tdata <= {{PadW{1'b0}}, chars_flat};
    end
  end

`ifndef NO_ASSERTIONS
  // Group position never reaches the unused code.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos != 2'd3)
    else $error("group position out of range");

  // A third byte always closes the group and reaches stage 1.
  a_third_emits: assert property (@(posedge clk) disable iff (rst)
    in_xfer && pos == lsbuu_pkg::PosThird |=> s1_valid && pos == lsbuu_pkg::PosFirst)
    else $error("third byte did not close the group");

  // Every delivered character is printable in the expected range.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0]   >= lsbuu_pkg::CharMin && m_tdata[6:0]   <= lsbuu_pkg::CharMax &&
                  m_tdata[13:7]  >= lsbuu_pkg::CharMin && m_tdata[13:7]  <= lsbuu_pkg::CharMax &&
                  m_tdata[20:14] >= lsbuu_pkg::CharMin && m_tdata[20:14] <= lsbuu_pkg::CharMax &&
                  m_tdata[27:21] >= lsbuu_pkg::CharMin && m_tdata[27:21] <= lsbuu_pkg::CharMax))
    else $error("character out of printable range");

  // A waiting stage-1 group is not lost while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_ready |=> s1_valid && $stable(s1_word))
    else $error("stage 1 group dropped during stall");
`endif

endmodule
